// ===== sv/krls_pkg.sv =====
`timescale 1ns / 1ps
package krls_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_PRESSED,
    PH_REPEAT
  } key_phase_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 3'd4;

  localparam logic [9:0]  LONG_PRESS_RST = 10'd50;
  localparam logic [9:0]  REPEAT_RST     = 10'd10;
  localparam logic [6:0]  LEVEL_STEP_RST = 7'd5;
  localparam logic [6:0]  LEVEL_MAX_RST  = 7'd100;
  localparam logic [7:0]  ANGLE_STEP_RST = 8'd90;
  localparam logic [6:0]  LEVEL_RST      = 7'd50;
  localparam logic [7:0]  ANGLE_RST      = 8'd90;

  localparam logic [7:0]  ANGLE_LIMIT    = 8'd180;
  localparam logic [11:0] PULSE_BASE     = 12'd500;
  // angle*2000/180 == floor(angle * 1456400 / 2^17) for angle in 0..180
  localparam logic [20:0] PULSE_MUL      = 21'd1456400;

  typedef struct packed {
    logic inc_key_down;
    logic dec_key_down;
  } in_t;

  typedef struct packed {
    logic [6:0]  level;
    logic [7:0]  servo_angle;
    logic [11:0] pulse_us;
    logic        inc_action;
    logic        dec_action;
  } out_t;

  typedef struct packed {
    logic [9:0] long_press_ticks;
    logic [9:0] repeat_ticks;
    logic [6:0] level_step;
    logic [6:0] level_max;
    logic [7:0] angle_step;
  } cfg_t;

  typedef struct packed {
    logic lvl;
    logic ang;
  } key_evt_t;

endpackage

// ===== sv/krls_key.sv =====
`timescale 1ns / 1ps
module krls_key import krls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       down,
  input  logic [9:0] long_press_ticks,
  input  logic [9:0] repeat_ticks,
  output key_evt_t   evt
);

  key_phase_t phase, phase_next;
  logic [9:0] hold_count, hold_count_next;
  logic [9:0] repeat_count, repeat_count_next;
  logic [9:0] hold_inc, repeat_inc;
  logic       repeat_hit;

  assign hold_inc   = hold_count + 10'd1;
  assign repeat_inc = repeat_count + 10'd1;
  assign repeat_hit = repeat_inc >= repeat_ticks;

  always_comb begin
    phase_next        = phase;
    hold_count_next   = hold_count;
    repeat_count_next = repeat_count;
    case (phase)
      PH_IDLE: begin
        if (down) phase_next = PH_DEBOUNCE;
      end
      PH_DEBOUNCE: begin
        if (down) begin
          hold_count_next = '0;
          phase_next      = PH_PRESSED;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (down) begin
          hold_count_next = hold_inc;
          if (hold_inc >= long_press_ticks) begin
            repeat_count_next = '0;
            phase_next        = PH_REPEAT;
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_REPEAT: begin
        if (down) begin
          repeat_count_next = repeat_hit ? 10'd0 : repeat_inc;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    evt = '0;
    case (phase)
      PH_DEBOUNCE: begin
        evt.lvl = down;
        evt.ang = down;
      end
      PH_REPEAT: begin
        evt.lvl = down && repeat_hit;
      end
      default: evt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      hold_count   <= '0;
      repeat_count <= '0;
    end else if (en) begin
      phase        <= phase_next;
      hold_count   <= hold_count_next;
      repeat_count <= repeat_count_next;
    end
  end

endmodule

// ===== sv/krls_pos.sv =====
`timescale 1ns / 1ps
module krls_pos import krls_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  cfg_t        cfg,
  input  key_evt_t    dec_evt,
  input  key_evt_t    inc_evt,
  output logic [6:0]  level_next,
  output logic [7:0]  angle_next,
  output logic [11:0] pulse_next
);

  logic [6:0]  level;
  logic [7:0]  angle;
  logic [6:0]  level_dec;
  logic [7:0]  angle_dec;
  logic [7:0]  level_sum;
  logic [8:0]  angle_sum;
  logic [28:0] pulse_prod;

  // decrease key first
  always_comb begin
    level_dec = level;
    angle_dec = angle;
    if (dec_evt.lvl) begin
      level_dec = (level >= cfg.level_step) ? level - cfg.level_step : 7'd0;
    end
    if (dec_evt.ang) begin
      angle_dec = (angle < cfg.angle_step) ? 8'd0 : angle - cfg.angle_step;
    end
  end

  assign level_sum = {1'b0, level_dec} + {1'b0, cfg.level_step};
  assign angle_sum = {1'b0, angle_dec} + {1'b0, cfg.angle_step};

  always_comb begin
    level_next = level_dec;
    angle_next = angle_dec;
    if (inc_evt.lvl) begin
      level_next = (level_sum <= {1'b0, cfg.level_max}) ? level_sum[6:0] : cfg.level_max;
    end
    if (inc_evt.ang) begin
      angle_next = (angle_sum > {1'b0, ANGLE_LIMIT}) ? ANGLE_LIMIT : angle_sum[7:0];
    end
  end

  assign pulse_prod = 29'(angle_next) * 29'(PULSE_MUL);
  assign pulse_next = PULSE_BASE + pulse_prod[28:17];

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RST;
      angle <= ANGLE_RST;
    end else if (en) begin
      level <= level_next;
      angle <= angle_next;
    end
  end

endmodule

// ===== sv/key_repeat_level_servo_control.sv =====
`timescale 1ns / 1ps
// Pipeline: a word accepted into the input register (s1_data) has its result
// registered into out_data when the input stage advances.
// Throughput: one word per cycle while results are taken; a stalled result
// holds one more word in the input register before ready drops.
// Reset (rst, synchronous): both keys idle, counts zero, level 50, angle 90,
// registers back to their defaults, no result pending.
module key_repeat_level_servo_control import krls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data
);

  cfg_t        cfg;
  logic        s1_valid;
  in_t         s1_data;
  logic        s1_adv;
  key_evt_t    dec_evt, inc_evt;
  logic [6:0]  level_next;
  logic [7:0]  angle_next;
  logic [11:0] pulse_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ticks <= LONG_PRESS_RST;
      cfg.repeat_ticks     <= REPEAT_RST;
      cfg.level_step       <= LEVEL_STEP_RST;
      cfg.level_max        <= LEVEL_MAX_RST;
      cfg.angle_step       <= ANGLE_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PRESS: cfg.long_press_ticks <= cfg_data;
        CFG_REPEAT:     cfg.repeat_ticks     <= cfg_data;
        CFG_LEVEL_STEP: cfg.level_step       <= cfg_data[6:0];
        CFG_LEVEL_MAX:  cfg.level_max        <= cfg_data[6:0];
        CFG_ANGLE_STEP: cfg.angle_step       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data <= in_data;
  end

  krls_key u_dec (
    .clk              (clk),
    .rst              (rst),
    .en               (s1_adv),
    .down             (s1_data.dec_key_down),
    .long_press_ticks (cfg.long_press_ticks),
    .repeat_ticks     (cfg.repeat_ticks),
    .evt              (dec_evt)
  );

  krls_key u_inc (
    .clk              (clk),
    .rst              (rst),
    .en               (s1_adv),
    .down             (s1_data.inc_key_down),
    .long_press_ticks (cfg.long_press_ticks),
    .repeat_ticks     (cfg.repeat_ticks),
    .evt              (inc_evt)
  );

  krls_pos u_pos (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_adv),
    .cfg        (cfg),
    .dec_evt    (dec_evt),
    .inc_evt    (inc_evt),
    .level_next (level_next),
    .angle_next (angle_next),
    .pulse_next (pulse_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.level       <= level_next;
      out_data.servo_angle <= angle_next;
      out_data.pulse_us    <= pulse_next;
      out_data.inc_action  <= inc_evt.lvl;
      out_data.dec_action  <= dec_evt.lvl;
    end
  end

endmodule

// ===== sv/krls_checker.sv =====
`timescale 1ns / 1ps
module krls_checker import krls_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.servo_angle <= ANGLE_LIMIT)
    else $error("servo angle above limit");

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.pulse_us >= 12'd500 && out_data.pulse_us <= 12'd2500)
    else $error("pulse width out of range");

endmodule

bind key_repeat_level_servo_control krls_checker u_krls_checker (.*);
